/* rtl/block_bitmap_allocator_defines.svh */
// Assertion macros for the block bitmap allocator RTL, included by bba_seq.
// No dependencies; the macros expect clk and arst_n in the enclosing scope.
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bba_pkg.sv */
// Package for the block bitmap allocator: widths, codes, payload structs and states.
// Used by every module of the block; depends on nothing.
package bba_pkg;

	localparam int MAX_BLOCKS_DEF    = 16384;
	localparam int MAP_WORD_BITS_DEF = 32;

	localparam int CNT_W     = 15;
	localparam int BLK_W     = 14;
	localparam int REQ_W     = 3;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_FREE   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FORMAT = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;

	localparam logic [CNT_W-1:0] TOTAL_RST    = 15'd16384;
	localparam logic [CNT_W-1:0] RESERVED_RST = 15'd0;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [BLK_W-1:0] block_index;
		logic             bit_value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BLK_W-1:0]  result_block;
		logic              read_bit;
		logic [CNT_W-1:0]  free_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_BIT,
		S_ALLOC,
		S_FORMAT,
		S_DONE
	} seq_state_t;

endpackage

/* rtl/bba_scan.sv */
// Lowest-clear-bit finder for one occupancy word during allocation.
// Depends on bba_pkg; instantiated by bba_seq.
module bba_scan
	import bba_pkg::*;
#(
	parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF,
	parameter int BASE_W        = CNT_W + 1
) (
	input  logic [MAP_WORD_BITS-1:0]         word,
	input  logic [BASE_W-1:0]                base,
	input  logic [CNT_W-1:0]                 total,
	output logic                             found,
	output logic [MAP_WORD_BITS-1:0]         pick,
	output logic [$clog2(MAP_WORD_BITS)-1:0] idx
);

	localparam int IW = $clog2(MAP_WORD_BITS);

	logic [BASE_W-1:0]        rem;
	logic [MAP_WORD_BITS-1:0] in_range;
	logic [MAP_WORD_BITS-1:0] cand;

	// Bits at or beyond the managed total never count as free.
	assign rem      = BASE_W'(total) - base;
	assign in_range = ~({MAP_WORD_BITS{1'b1}} << rem);
	assign cand     = ~word & in_range;
	assign found    = |cand;
	// Isolate the lowest set bit of the candidate vector.
	assign pick     = cand & (~cand + MAP_WORD_BITS'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < MAP_WORD_BITS; i++) begin
			if (pick[i]) begin
				idx = idx | IW'(i);
			end
		end
	end

endmodule

/* rtl/bba_seq.sv */
// Sequencer and occupancy map memory of the block bitmap allocator.
// Depends on bba_pkg, bba_scan and the assertion macros header.
`include "block_bitmap_allocator_defines.svh"

module bba_seq
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
	parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_fire,
	input  req_t             req,
	input  logic [CNT_W-1:0] total,
	input  logic [CNT_W-1:0] reserved,
	input  logic             out_room,
	output logic             busy,
	output logic             done,
	output rsp_t             rsp
);

	localparam int WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SHIFT = $clog2(MAP_WORD_BITS);
	localparam int XW    = (AW + SHIFT + 1 > CNT_W + 1) ? AW + SHIFT + 1 : CNT_W + 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
	localparam logic [XW-1:0] WORD_STEP = XW'(MAP_WORD_BITS);

	seq_state_t state_q, state_d;

	logic [MAP_WORD_BITS-1:0] mem [WORDS];
	logic [MAP_WORD_BITS-1:0] rdata_s1;

	logic [CNT_W-1:0]  free_q;
	logic [REQ_W-1:0]  op_q;
	logic [BLK_W-1:0]  blk_q;
	logic              val_q;
	logic [STAT_W-1:0] stat_q;
	logic [CNT_W-1:0]  rblk_q;
	logic              rbit_q;
	logic [XW-1:0]     base_q;
	logic [XW-1:0]     base_s1;
	logic              rd_v_s1;
	logic [AW-1:0]     fcnt_q;

	logic                     mem_we;
	logic [AW-1:0]            waddr;
	logic [MAP_WORD_BITS-1:0] wdata;
	logic [AW-1:0]            raddr;

	logic                     in_range;
	logic [MAP_WORD_BITS-1:0] bit_mask;
	logic                     scan_found;
	logic                     hit;
	logic [MAP_WORD_BITS-1:0] scan_pick;
	logic [SHIFT-1:0]         scan_idx;
	logic                     issue;
	logic                     scan_end;
	logic [XW-1:0]            fbase;
	logic [XW-1:0]            fres;
	logic [MAP_WORD_BITS-1:0] fword;

	bba_scan #(
		.MAP_WORD_BITS(MAP_WORD_BITS),
		.BASE_W       (XW)
	) u_scan (
		.word (rdata_s1),
		.base (base_s1),
		.total(total),
		.found(scan_found),
		.pick (scan_pick),
		.idx  (scan_idx)
	);

	assign in_range = CNT_W'(req.block_index) < total;
	assign bit_mask = MAP_WORD_BITS'(1) << blk_q[SHIFT-1:0];
	assign hit      = rd_v_s1 && scan_found;
	assign issue    = !hit && (base_q < XW'(total));
	assign scan_end = !hit && !rd_v_s1 && !issue;

	// Format word: reserved blocks busy, everything else clear; the clearing sweep clears all.
	assign fbase = XW'(fcnt_q) << SHIFT;
	assign fres  = (state_q == S_CLEAR) ? '0 : XW'(reserved);
	assign fword = (fbase < fres) ? ~({MAP_WORD_BITS{1'b1}} << (fres - fbase)) : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (fcnt_q == LAST_WORD) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_fire) begin
					case (req.req_type)
						REQ_ALLOC:  state_d = (free_q == '0) ? S_DONE : S_ALLOC;
						REQ_FREE,
						REQ_READ,
						REQ_WRITE:  state_d = in_range ? S_BIT : S_DONE;
						REQ_FORMAT: state_d = S_FORMAT;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_BIT: state_d = S_DONE;
			S_ALLOC: begin
				if (hit || scan_end) begin
					state_d = S_DONE;
				end
			end
			S_FORMAT: begin
				if (fcnt_q == LAST_WORD) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_room) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != S_IDLE);
		done   = 1'b0;
		mem_we = 1'b0;
		waddr  = AW'(blk_q >> SHIFT);
		wdata  = rdata_s1;
		raddr  = AW'(req.block_index >> SHIFT);
		case (state_q)
			S_CLEAR,
			S_FORMAT: begin
				mem_we = 1'b1;
				waddr  = fcnt_q;
				wdata  = fword;
			end
			S_BIT: begin
				case (op_q)
					REQ_FREE: begin
						mem_we = free_q < total;
						wdata  = rdata_s1 & ~bit_mask;
					end
					REQ_WRITE: begin
						mem_we = 1'b1;
						wdata  = val_q ? (rdata_s1 | bit_mask) : (rdata_s1 & ~bit_mask);
					end
					default: mem_we = 1'b0;
				endcase
			end
			S_ALLOC: begin
				raddr  = AW'(base_q >> SHIFT);
				mem_we = hit;
				waddr  = AW'(base_s1 >> SHIFT);
				wdata  = rdata_s1 | scan_pick;
			end
			S_DONE: done = out_room;
			default: done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			free_q  <= '0;
			rd_v_s1 <= 1'b0;
			fcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == S_ALLOC) && issue;
			case (state_q)
				S_CLEAR: fcnt_q <= fcnt_q + AW'(1);
				S_IDLE:  fcnt_q <= '0;
				S_FORMAT: begin
					fcnt_q <= fcnt_q + AW'(1);
					if (fcnt_q == LAST_WORD) begin
						free_q <= total - reserved;
					end
				end
				S_BIT: begin
					if (op_q == REQ_FREE && free_q < total) begin
						free_q <= free_q + CNT_W'(1);
					end
				end
				S_ALLOC: begin
					if (hit) begin
						free_q <= free_q - CNT_W'(1);
					end
				end
				default: free_q <= free_q;
			endcase
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_fire) begin
			op_q   <= req.req_type;
			blk_q  <= req.block_index;
			val_q  <= req.bit_value;
			rblk_q <= '0;
			rbit_q <= 1'b0;
			base_q <= '0;
			stat_q <= STAT_OK;
			case (req.req_type)
				REQ_ALLOC: begin
					if (free_q == '0) begin
						stat_q <= STAT_NOFREE;
					end
				end
				REQ_FREE,
				REQ_READ,
				REQ_WRITE: begin
					if (!in_range) begin
						stat_q <= STAT_RANGE;
					end
				end
				default: stat_q <= STAT_OK;
			endcase
		end else if (state_q == S_BIT) begin
			if (op_q == REQ_FREE) begin
				rblk_q <= CNT_W'(blk_q);
			end
			if (op_q == REQ_READ) begin
				rbit_q <= |(rdata_s1 & bit_mask);
			end
		end else if (state_q == S_ALLOC) begin
			base_s1 <= base_q;
			if (issue) begin
				base_q <= base_q + WORD_STEP;
			end
			if (hit) begin
				rblk_q <= CNT_W'(base_s1) | CNT_W'(scan_idx);
			end else if (scan_end) begin
				stat_q <= STAT_NOFREE;
			end
		end
	end

	assign rsp.status       = stat_q;
	assign rsp.result_block = BLK_W'(rblk_q);
	assign rsp.read_bit     = rbit_q;
	assign rsp.free_count   = free_q;

	`BBA_ASSERT_IMP(a_req_only_idle, req_fire, state_q == S_IDLE, "request taken while busy")
	`BBA_ASSERT_IMP(a_we_state, mem_we, (state_q == S_BIT || state_q == S_ALLOC || state_q == S_FORMAT || state_q == S_CLEAR), "map written outside an update state")
	`BBA_ASSERT_IMP(a_alloc_count, (state_q == S_ALLOC && mem_we), free_q != '0, "allocation with empty counter")
	`BBA_ASSERT_IMP(a_scan_bound, rd_v_s1, base_s1 < XW'(total), "scanned word beyond the managed total")
	`BBA_ASSERT_NXT(a_done_idle, done, state_q == S_IDLE, "sequencer not idle after result transfer")

endmodule

/* rtl/block_bitmap_allocator.sv */
// Top level of the block bitmap allocator: ports, configuration registers, result register.
// Depends on bba_pkg and bba_seq (which holds the occupancy map and bba_scan).
//
// Channel   Direction  Handshake             Payload
// req       in         req_valid / req_stall req_data  (req_t)
// rsp       out        rsp_valid / rsp_stall rsp_data  (rsp_t)
// cfg       in         cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// Free, read bit and write bit pass through S_BIT to S_DONE before the result transfer;
// an allocation with the counter at zero, an out-of-range or an unknown request goes
// straight to S_DONE. Allocate scans one map word per cycle up to the first clear block
// or, when none is found, through the words under the total. Format rewrites every map
// word. After reset a clearing sweep of one word per cycle holds req_stall high. A finished
// result waits in the output register while rsp_stall is high; the next request is taken
// meanwhile, and its own result waits in the sequencer.
module block_bitmap_allocator
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
	parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_wdata
);

	// The managed total is capped at the map size and at the largest total the counter can express.
	localparam int CAP = (MAX_BLOCKS > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : MAX_BLOCKS;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);

	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] reserved_q;
	logic [CNT_W-1:0] eff_total;
	logic [CNT_W-1:0] eff_reserved;
	logic             req_fire;
	logic             seq_busy;
	logic             seq_done;
	logic             out_room;
	rsp_t             seq_rsp;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// Configuration is accepted on every cycle. The block does not enforce it; the user
	// must only write while it is idle, so the effective values stay stable during a request.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RST;
			reserved_q <= RESERVED_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TOTAL:    total_q    <= cfg_wdata;
				CFG_RESERVED: reserved_q <= cfg_wdata;
				default:      total_q    <= total_q;
			endcase
		end
	end

	// A total above the map size manages only the map; reserved is capped at the total.
	assign eff_total    = (total_q > CAP_C) ? CAP_C : total_q;
	assign eff_reserved = (reserved_q > eff_total) ? eff_total : reserved_q;

	assign req_stall = seq_busy;
	assign req_fire  = req_valid && !req_stall;

	// The output register may be refilled in the cycle its current result is taken.
	assign out_room = !rsp_valid_q || !rsp_stall;

	bba_seq #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.MAP_WORD_BITS(MAP_WORD_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_fire(req_fire),
		.req     (req_data),
		.total   (eff_total),
		.reserved(eff_reserved),
		.out_room(out_room),
		.busy    (seq_busy),
		.done    (seq_done),
		.rsp     (seq_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (seq_done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			rsp_q <= seq_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

/* test/block_bitmap_allocator_tb.sv */
// Self-checking testbench for block_bitmap_allocator: directed and random requests, checked
// against an occupancy map and free counter kept here. Depends on bba_pkg and the RTL only.
module block_bitmap_allocator_tb;
	import bba_pkg::*;

	// Slowest correct run: about 2200 requests, each at worst a full allocation scan
	// plus the longest sender gap and receiver stall; the limit sits well above that.
	localparam int CYCLE_LIMIT   = 5000000;
	localparam int TAIL_CYCLES   = 600;
	localparam int RANDOM_TARGET = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req_data = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TOTAL;
	logic [CNT_W-1:0]     cfg_wdata = '0;

	block_bitmap_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the block's state. A set bit in occ_map means the block is busy.
	bit               occ_map [MAX_BLOCKS_DEF];
	logic [CNT_W-1:0] free_ctr = '0;
	logic [CNT_W-1:0] total_cfg = TOTAL_RST;
	logic [CNT_W-1:0] reserved_cfg = RESERVED_RST;

	req_t req_backlog [$];
	rsp_t answers_due [$];

	int unsigned errors = 0;
	int unsigned cycle_cnt = 0;
	int unsigned n_answered = 0;
	int unsigned n_ok = 0;
	int unsigned n_nofree = 0;
	int unsigned n_range = 0;
	int unsigned n_settings = 0;
	int unsigned n_queued = 0;

	// A total above the map size behaves as the map size; zero manages nothing.
	function automatic int unsigned managed_blocks(input logic [CNT_W-1:0] total);
		return (total > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(total);
	endfunction

	// Applies one request to the shadow state and returns the answer it must produce.
	function automatic rsp_t serve_request(input req_t rq);
		int unsigned tot;
		int unsigned keep;
		int unsigned b;
		bit          found;
		rsp_t        ans;
		tot = managed_blocks(total_cfg);
		ans = '0;
		ans.status = STAT_OK;
		found = 1'b0;
		case (rq.req_type)
			REQ_ALLOC: begin
				// A nonzero counter does not promise a clear bit: the scan may still fail.
				ans.status = STAT_NOFREE;
				if (free_ctr != 0) begin
					for (b = 0; b < tot && !found; b++) begin
						if (!occ_map[b]) begin
							occ_map[b] = 1'b1;
							free_ctr = free_ctr - 1'b1;
							ans.result_block = b[BLK_W-1:0];
							ans.status = STAT_OK;
							found = 1'b1;
						end
					end
				end
			end
			REQ_FREE: begin
				if (rq.block_index >= tot) begin
					ans.status = STAT_RANGE;
				end else begin
					ans.result_block = rq.block_index;
					// With the counter already full the bit is left as it is.
					if (free_ctr < tot) begin
						occ_map[rq.block_index] = 1'b0;
						free_ctr = free_ctr + 1'b1;
					end
				end
			end
			REQ_READ: begin
				if (rq.block_index >= tot)
					ans.status = STAT_RANGE;
				else
					ans.read_bit = occ_map[rq.block_index];
			end
			REQ_WRITE: begin
				if (rq.block_index >= tot)
					ans.status = STAT_RANGE;
				else
					occ_map[rq.block_index] = rq.bit_value;
			end
			REQ_FORMAT: begin
				keep = (reserved_cfg > tot) ? tot : int'(reserved_cfg);
				for (b = 0; b < MAX_BLOCKS_DEF; b++)
					occ_map[b] = (b < keep);
				free_ctr = CNT_W'(tot - keep);
			end
			default: begin
			end
		endcase
		ans.free_count = free_ctr;
		return ans;
	endfunction

	// Random request for a map managing tot blocks. Indices favour the managed range
	// but also hit its upper edge, the top index and anything at all.
	function automatic req_t random_request(input int unsigned tot);
		req_t        rq;
		int unsigned pick;
		rq.block_index = BLK_W'($urandom);
		rq.bit_value = 1'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 38)
			rq.req_type = REQ_ALLOC;
		else if (pick < 62)
			rq.req_type = REQ_FREE;
		else if (pick < 76)
			rq.req_type = REQ_READ;
		else if (pick < 90)
			rq.req_type = REQ_WRITE;
		else if (pick < 94)
			rq.req_type = REQ_FORMAT;
		else
			rq.req_type = REQ_W'($urandom_range(REQ_FORMAT + 1, {REQ_W{1'b1}}));
		case ($urandom_range(0, 9))
			0: rq.block_index = BLK_W'($urandom);
			1: rq.block_index = tot[BLK_W-1:0];
			2: rq.block_index = {BLK_W{1'b1}};
			default: begin
				if (tot != 0)
					rq.block_index = BLK_W'($urandom_range(0, tot - 1));
			end
		endcase
		return rq;
	endfunction

	// Sender. A request is taken when the block accepts the current transfer; the
	// prediction is made at that same edge, so it sees requests in arrival order.
	// Work comes in bursts of random length, separated by gaps that are sometimes empty
	// and now and then long.
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin : drive_requests
		logic nxt_valid;
		req_t nxt_data;
		nxt_valid = req_valid;
		nxt_data = req_data;
		if (req_valid && !req_stall) begin
			answers_due.push_back(serve_request(req_data));
			nxt_valid = 1'b0;
		end
		if (!nxt_valid) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (req_backlog.size() > 0) begin
				nxt_data = req_backlog.pop_front();
				nxt_valid = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					if ($urandom_range(0, 3) == 0)
						gap_left = 0;
					else if ($urandom_range(0, 9) == 0)
						gap_left = $urandom_range(20, 40);
					else
						gap_left = $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
		end
		// One assignment per signal and edge, so back-to-back transfers keep valid high.
		req_valid <= nxt_valid;
		req_data <= nxt_data;
	end

	// Receiver. Checks each result transfer against the oldest prediction and stalls on
	// a pattern picked anew at random for each stretch: never, sparse random, a regular
	// duty cycle, or mostly stalled.
	int unsigned stall_mode = 0;
	int unsigned mode_left = 0;
	int unsigned mode_tick = 0;

	always @(posedge clk) begin : check_results
		rsp_t want;
		bit   bad;
		logic nxt_stall;
		if (rsp_valid && !rsp_stall) begin
			if (answers_due.size() == 0) begin
				$error("result transfer with nothing expected: %h", rsp_data);
				errors++;
			end else begin
				want = answers_due.pop_front();
				bad = 1'b0;
				n_answered++;
				if (rsp_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_data.status);
					bad = 1'b1;
				end
				if (rsp_data.result_block !== want.result_block) begin
					$error("result_block: expected %0d, got %0d",
						want.result_block, rsp_data.result_block);
					bad = 1'b1;
				end
				if (rsp_data.read_bit !== want.read_bit) begin
					$error("read_bit: expected %0d, got %0d", want.read_bit, rsp_data.read_bit);
					bad = 1'b1;
				end
				if (rsp_data.free_count !== want.free_count) begin
					$error("free_count: expected %0d, got %0d",
						want.free_count, rsp_data.free_count);
					bad = 1'b1;
				end
				if (bad)
					errors++;
				case (want.status)
					STAT_OK: n_ok++;
					STAT_NOFREE: n_nofree++;
					default: n_range++;
				endcase
			end
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 400);
			mode_tick = 0;
		end else begin
			mode_left--;
		end
		mode_tick++;
		case (stall_mode)
			0: nxt_stall = 1'b0;
			1: nxt_stall = ($urandom_range(0, 3) == 0);
			2: nxt_stall = ((mode_tick % 8) < 3);
			default: nxt_stall = ($urandom_range(0, 3) != 0);
		endcase
		rsp_stall <= nxt_stall;
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_cnt, answers_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_request(input logic [REQ_W-1:0] kind, input int unsigned idx,
		input bit value);
		req_t rq;
		rq.req_type = kind;
		rq.block_index = idx[BLK_W-1:0];
		rq.bit_value = value;
		req_backlog.push_back(rq);
	endtask

	// Holds the stimulus back until every queued request has been answered. Doing this
	// before each change of settings also gives the pause with nothing in flight. The
	// check runs on the falling edge, once the sender and receiver have settled.
	task automatic wait_idle();
		@(negedge clk);
		while (req_backlog.size() != 0 || answers_due.size() != 0 || req_valid)
			@(negedge clk);
	endtask

	// Register write; the shadow copy follows at the edge of the transfer.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_TOTAL)
			total_cfg = value;
		else if (idx == CFG_RESERVED)
			reserved_cfg = value;
	endtask

	task automatic new_settings(input logic [CNT_W-1:0] tot, input logic [CNT_W-1:0] res);
		wait_idle();
		write_reg(CFG_TOTAL, tot);
		write_reg(CFG_RESERVED, res);
		n_settings++;
	endtask

	// One stretch of random traffic under fixed settings. Leaving out the leading
	// format keeps the counter from the previous settings, which is legal behaviour.
	task automatic random_phase(input logic [CNT_W-1:0] tot, input logic [CNT_W-1:0] res,
		input int unsigned count, input bit format_first);
		req_t rq;
		new_settings(tot, res);
		if (format_first)
			queue_request(REQ_FORMAT, $urandom, 1'($urandom));
		repeat (count) begin
			rq = random_request(managed_blocks(tot));
			req_backlog.push_back(rq);
			if (rq.req_type <= REQ_FORMAT)
				n_queued++;
		end
	endtask

	initial begin : stimulus
		int unsigned b;
		int unsigned tot;
		int unsigned res;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings, empty map, counter at zero. The map clearing pass after reset
		// simply holds off the first transfer.
		queue_request(REQ_ALLOC, 0, 1'b0);            // counter zero: no free block
		queue_request(REQ_FREE, 5, 1'b0);             // freeing a clear block still counts
		queue_request(REQ_ALLOC, 0, 1'b0);
		queue_request(REQ_READ, 0, 1'b0);
		queue_request(REQ_READ, {BLK_W{1'b1}}, 1'b1);
		queue_request(REQ_WRITE, {BLK_W{1'b1}}, 1'b1);
		queue_request(REQ_READ, {BLK_W{1'b1}}, 1'b0);
		queue_request(REQ_WRITE, {BLK_W{1'b1}}, 1'b0);
		for (b = REQ_FORMAT + 1; b <= {REQ_W{1'b1}}; b++)
			queue_request(b[REQ_W-1:0], {BLK_W{1'b1}}, 1'b1);
		queue_request(REQ_FORMAT, 0, 1'b0);
		queue_request(REQ_FREE, 3, 1'b0);             // counter already full
		queue_request(REQ_ALLOC, 0, 1'b0);

		// Small map: fill every clear block by bit writes, so the counter stays
		// nonzero while allocation finds nothing; then index range checks.
		new_settings(10, 3);
		queue_request(REQ_FORMAT, 0, 1'b0);
		for (b = 3; b < 10; b++)
			queue_request(REQ_WRITE, b, 1'b1);
		queue_request(REQ_ALLOC, 0, 1'b0);
		queue_request(REQ_READ, 10, 1'b0);
		queue_request(REQ_FREE, 9, 1'b0);
		queue_request(REQ_ALLOC, 0, 1'b0);
		queue_request(REQ_WRITE, 10, 1'b1);

		// Extreme settings: reserved above total, no managed blocks, a single block,
		// register maxima, a full map with everything reserved, and a total shrunk
		// after format without reformatting.
		random_phase(10, 20, 20, 1'b1);
		random_phase(0, 0, 20, 1'b0);
		random_phase(1, 0, 30, 1'b1);
		random_phase({CNT_W{1'b1}}, {CNT_W{1'b1}}, 25, 1'b1);
		random_phase(CNT_W'(MAX_BLOCKS_DEF), CNT_W'(MAX_BLOCKS_DEF), 30, 1'b1);
		random_phase(CNT_W'(MAX_BLOCKS_DEF), 0, 150, 1'b1);
		random_phase(64, 4, 60, 1'b1);
		random_phase(16, 0, 60, 1'b0);

		// Random settings, mostly small maps so allocation scans stay short.
		while (n_queued < RANDOM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				tot = $urandom_range(1025, MAX_BLOCKS_DEF);
			else
				tot = $urandom_range(1, 1024);
			if ($urandom_range(0, 7) == 0)
				res = tot + $urandom_range(0, 8);
			else
				res = $urandom_range(0, tot / 4);
			random_phase(CNT_W'(tot), CNT_W'(res), $urandom_range(40, 120),
				$urandom_range(0, 4) != 0);
		end

		wait_idle();
		// Allow for the longest scan in case a stray result is still on its way.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results over %0d register settings in %0d cycles.",
			n_answered, n_settings + 1, cycle_cnt);
		$display("Status mix: %0d ok, %0d without a free block, %0d out of range.",
			n_ok, n_nofree, n_range);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d results did not match", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* block_bitmap_allocator.f */
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_scan.sv
rtl/bba_seq.sv
rtl/block_bitmap_allocator.sv
test/block_bitmap_allocator_tb.sv
